// ===== design/xyzl_pkg.sv =====
// Shared constants for the XYZ to CIELAB converter.
// Used by xyzl_f, xyz_to_cielab and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xyzl_pkg;

    localparam int F_BITS     = 18;   // fractional bits of the f values
    localparam int FW         = 21;   // width of an f value
    localparam int DIV_STEPS  = 62;   // quotient bits of t * 2^54
    localparam int LIN_STEPS  = 18;   // quotient bits of the linear branch
    localparam int ROOT_STEPS = 21;   // cube root digits
    localparam int F_LAT      = 1 + DIV_STEPS + ROOT_STEPS;

    localparam logic [23:0] WHITE_MIN = 24'd65536;

    localparam int L_MAX = 37248;
    localparam int A_LIM = 160448;
    localparam int B_LIM = 64256;

    localparam logic [1:0] IDX_WHITE_X = 2'd0;
    localparam logic [1:0] IDX_WHITE_Y = 2'd1;
    localparam logic [1:0] IDX_WHITE_Z = 2'd2;

endpackage

`default_nettype wire

// ===== design/xyzl_f.sv =====
// Pipelined CIELAB transfer function f(v / w) for one component.
// Uses xyzl_pkg; accepts one request per cycle.
`timescale 1ns / 1ps
`default_nettype none

module xyzl_f
    import xyzl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic [23:0]   v,
    input  wire logic [23:0]   w,
    output logic      [FW-1:0] f
);

    localparam int RW = 48;

    logic [23:0] wc;
    logic [39:0] cube_lhs;
    logic [39:0] cube_rhs;

    logic [23:0] w_reg  [0:DIV_STEPS];
    logic [23:0] dr_reg [0:DIV_STEPS];
    logic [61:0] dq_reg [0:DIV_STEPS];
    logic [7:0]  dlo_reg[0:DIV_STEPS];

    logic [40:0] lr_reg [0:LIN_STEPS];
    logic [35:0] le_reg [0:LIN_STEPS];

    logic              cube_reg [0:F_LAT-1];
    logic [LIN_STEPS-1:0] lq_reg [0:F_LAT-1];

    logic [62:0]   rn_reg [1:ROOT_STEPS];
    logic [RW-1:0] rr_reg [1:ROOT_STEPS];
    logic [20:0]   ry_reg [1:ROOT_STEPS];
    logic [41:0]   ry2_reg[1:ROOT_STEPS];

    assign wc       = (w < WHITE_MIN) ? WHITE_MIN : w;
    assign cube_lhs = 40'(v) * 40'd24389;
    assign cube_rhs = 40'(wc) * 40'd216;

    // Since v < 256 * w, v / 256 is already a valid partial remainder.
    always_ff @(posedge clk)
    begin
        w_reg[0]    <= wc;
        dr_reg[0]   <= 24'(v[23:8]);
        dq_reg[0]   <= '0;
        dlo_reg[0]  <= v[7:0];
        lr_reg[0]   <= 41'(v) * 41'd24389 + 41'(wc) * 41'd432;
        le_reg[0]   <= 36'(wc) * 36'd3132;
        cube_reg[0] <= cube_lhs > cube_rhs;
        lq_reg[0]   <= '0;
    end

    // Restoring division producing floor(v * 2^54 / w), one bit a stage.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [24:0] r2;
        logic        ge;
        assign r2 = {dr_reg[k], dlo_reg[k][7]};
        assign ge = r2 >= {1'b0, w_reg[k]};
        always_ff @(posedge clk)
        begin
            w_reg[k+1]   <= w_reg[k];
            dr_reg[k+1]  <= ge ? 24'(r2 - {1'b0, w_reg[k]}) : r2[23:0];
            dq_reg[k+1]  <= {dq_reg[k][60:0], ge};
            dlo_reg[k+1] <= {dlo_reg[k][6:0], 1'b0};
        end
    end

    // Linear branch division and carrying of the branch decision.
    for (genvar s = 0; s < F_LAT - 1; s++)
    begin : g_carry
        if (s < LIN_STEPS)
        begin : g_lin
            logic [41:0] lr2;
            logic        lge;
            assign lr2 = {lr_reg[s], 1'b0};
            assign lge = lr2 >= 42'(le_reg[s]);
            always_ff @(posedge clk)
            begin
                lr_reg[s+1] <= lge ? 41'(lr2 - 42'(le_reg[s])) : lr2[40:0];
                le_reg[s+1] <= le_reg[s];
                lq_reg[s+1] <= {lq_reg[s][LIN_STEPS-2:0], lge};
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                lq_reg[s+1] <= lq_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            cube_reg[s+1] <= cube_reg[s];
        end
    end

    // Digit-by-digit cube root: three radicand bits per stage, tracking y and y^2.
    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        logic [62:0]   n_in;
        logic [RW-1:0] r_in;
        logic [20:0]   y_in;
        logic [41:0]   y2_in;
        logic [RW-1:0] rs;
        logic [RW-1:0] d;
        logic          ge;
        if (j == 0)
        begin : g_first
            assign n_in  = {1'b0, dq_reg[DIV_STEPS]};
            assign r_in  = '0;
            assign y_in  = '0;
            assign y2_in = '0;
        end
        else
        begin : g_next
            assign n_in  = rn_reg[j];
            assign r_in  = rr_reg[j];
            assign y_in  = ry_reg[j];
            assign y2_in = ry2_reg[j];
        end
        assign rs = {r_in[RW-4:0], n_in[62:60]};
        assign d  = {3'b0, y2_in, 3'b0} + {4'b0, y2_in, 2'b0}
                  + {25'b0, y_in, 2'b0} + {26'b0, y_in, 1'b0} + RW'(1);
        assign ge = rs >= d;
        always_ff @(posedge clk)
        begin
            rn_reg[j+1]  <= {n_in[59:0], 3'b0};
            rr_reg[j+1]  <= ge ? rs - d : rs;
            ry_reg[j+1]  <= {y_in[19:0], ge};
            ry2_reg[j+1] <= ge ? {y2_in[39:0], 2'b0} + 42'({y_in, 2'b0}) + 42'd1
                               : {y2_in[39:0], 2'b0};
        end
    end

    assign f = cube_reg[F_LAT-1] ? ry_reg[ROOT_STEPS] : FW'(lq_reg[F_LAT-1]);

endmodule

`default_nettype wire

// ===== design/xyz_to_cielab.sv =====
// Top level of the CIE XYZ to CIELAB converter.
// Uses xyzl_pkg and three xyzl_f instances.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request is taken at a rising edge with start high and busy low. busy is
// always low, so one color can be presented in every cycle.
// x_value, y_value and z_value are unsigned with IN_FRAC_BITS fractional bits.
// Each result appears on lightness, a_axis and b_axis for one cycle with done
// high, after 1 prepare stage, 62 restoring division stages, 21 cube root
// stages and 2 output stages. Throughput is one color per clock, set by the
// fully pipelined divider and cube root.
// The receiver cannot stall; results are never held back.
// The white point is written through wr_en, wr_index and wr_data; the user must
// write it only while no request is in flight, as the block does not enforce it.
// Unknown indexes are ignored. Reset clears the pipeline valid bits and loads the D65 white point.

module xyz_to_cielab
    import xyzl_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 16,
    parameter int OUT_FRAC_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [23:0] x_value,
    input  wire logic [23:0] y_value,
    input  wire logic [23:0] z_value,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [23:0] wr_data,
    output logic             done,
    output logic [15:0]      lightness,
    output logic signed [18:0] a_axis,
    output logic signed [16:0] b_axis
);

    localparam longint WX_RAW = ((64'd950489 << IN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint WY_RAW = ((64'd1000000 << IN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint WZ_RAW = ((64'd1088840 << IN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [23:0] WX_RST = (WX_RAW > 64'hFFFFFF) ? 24'hFFFFFF : 24'(WX_RAW);
    localparam logic [23:0] WY_RST = (WY_RAW > 64'hFFFFFF) ? 24'hFFFFFF : 24'(WY_RAW);
    localparam logic [23:0] WZ_RST = (WZ_RAW > 64'hFFFFFF) ? 24'hFFFFFF : 24'(WZ_RAW);

    localparam int PW = 33 + OUT_FRAC_BITS;
    localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (F_BITS - 1);
    localparam logic signed [PW-1:0] LMAXP = PW'(L_MAX);
    localparam logic signed [PW-1:0] AMAXP = PW'(A_LIM);
    localparam logic signed [PW-1:0] AMINP = -PW'(A_LIM);
    localparam logic signed [PW-1:0] BMAXP = PW'(B_LIM);
    localparam logic signed [PW-1:0] BMINP = -PW'(B_LIM);

    logic [23:0] wx_reg, wy_reg, wz_reg;
    logic [F_LAT+1:0] vld_reg;
    logic [FW-1:0] fx, fy, fz;

    logic signed [31:0] lp_reg, ap_reg, bp_reg;
    logic signed [PW-1:0] ls, as_s, bs;

    logic [15:0]        l_next;
    logic signed [18:0] a_next;
    logic signed [16:0] b_next;
    logic [15:0]        l_reg;
    logic signed [18:0] a_reg;
    logic signed [16:0] b_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg <= WX_RST;
            wy_reg <= WY_RST;
            wz_reg <= WZ_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == IDX_WHITE_X)
                wx_reg <= wr_data;
            if (wr_index == IDX_WHITE_Y)
                wy_reg <= wr_data;
            if (wr_index == IDX_WHITE_Z)
                wz_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[F_LAT:0], start & ~busy};
    end

    xyzl_f u_fx (.clk(clk), .v(x_value), .w(wx_reg), .f(fx));
    xyzl_f u_fy (.clk(clk), .v(y_value), .w(wy_reg), .f(fy));
    xyzl_f u_fz (.clk(clk), .v(z_value), .w(wz_reg), .f(fz));

    always_ff @(posedge clk)
    begin
        lp_reg <= 32'(fy) * 32'sd116 - (32'sd16 <<< F_BITS);
        ap_reg <= (32'(fx) - 32'(fy)) * 32'sd500;
        bp_reg <= (32'(fy) - 32'(fz)) * 32'sd200;
    end

    // Rescale with round half up, then saturate.
    assign ls   = ((PW'(lp_reg) <<< OUT_FRAC_BITS) + HALF) >>> F_BITS;
    assign as_s = ((PW'(ap_reg) <<< OUT_FRAC_BITS) + HALF) >>> F_BITS;
    assign bs   = ((PW'(bp_reg) <<< OUT_FRAC_BITS) + HALF) >>> F_BITS;

    always_comb
    begin
        if (ls < 0)
            l_next = '0;
        else if (ls > LMAXP)
            l_next = 16'(LMAXP);
        else
            l_next = ls[15:0];

        if (as_s < AMINP)
            a_next = 19'(AMINP);
        else if (as_s > AMAXP)
            a_next = 19'(AMAXP);
        else
            a_next = as_s[18:0];

        if (bs < BMINP)
            b_next = 17'(BMINP);
        else if (bs > BMAXP)
            b_next = 17'(BMAXP);
        else
            b_next = bs[16:0];
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done      = vld_reg[F_LAT+1];
    assign lightness = l_reg;
    assign a_axis    = a_reg;
    assign b_axis    = b_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (lightness <= 16'(L_MAX)))
        else $error("lightness out of range");

    a_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (a_axis >= -19'sd160448 && a_axis <= 19'sd160448))
        else $error("a_axis out of range");

    a_b_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (b_axis >= -17'sd64256 && b_axis <= 17'sd64256))
        else $error("b_axis out of range");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for xyz_to_cielab: random and corner colors under several white points.
// Depends on xyzl_pkg and the xyz_to_cielab RTL only.
`timescale 1ns / 1ps

module tb;
    import xyzl_pkg::*;

    localparam int LATENCY   = 86;
    localparam int MAX_ERR   = 10;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } color_t;

    typedef struct packed {
        logic [15:0]        l;
        logic signed [18:0] a;
        logic signed [16:0] b;
    } lab_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [23:0] x_value = '0;
    logic [23:0] y_value = '0;
    logic [23:0] z_value = '0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [23:0] wr_data = '0;
    logic        done;
    logic [15:0] lightness;
    logic signed [18:0] a_axis;
    logic signed [16:0] b_axis;

    xyz_to_cielab i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_value(x_value), .y_value(y_value), .z_value(z_value),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .lightness(lightness), .a_axis(a_axis), .b_axis(b_axis)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    color_t pending_colors[$];
    lab_t   expected_lab[$];
    logic [23:0] wp_x = 24'd6229125;
    logic [23:0] wp_y = 24'd6553600;
    logic [23:0] wp_z = 24'd7135822;
    int     mismatches = 0;
    int     checked = 0;
    int     configs = 0;
    longint cycles = 0;
    bit     drain_done = 1'b0;

    // f(v / w) with 18 fractional bits, exact as the block defines it.
    function automatic longint lab_curve(logic [23:0] v, logic [23:0] w_in);
        logic [63:0] w, q, r, n, y, c;
        w = (w_in < WHITE_MIN) ? 64'(WHITE_MIN) : 64'(w_in);
        if (64'(v) * 24389 > 216 * w)
        begin
            q = 64'(v) / w;
            r = 64'(v) % w;
            for (int i = 0; i < 3 * F_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= w)
                begin
                    r = r - w;
                    q[0] = 1'b1;
                end
            end
            n = q;
            y = 0;
            for (int bt = 20; bt >= 0; bt--)
            begin
                c = y | (64'd1 << bt);
                if (c * c * c <= n)
                    y = c;
            end
            return longint'(y);
        end
        return longint'(((64'(v) * 24389 + 432 * w) << F_BITS) / (3132 * w));
    endfunction

    function automatic longint to_out_scale(longint x);
        return (x * 256 + (64'sd1 <<< (F_BITS - 1))) >>> F_BITS;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic lab_t convert_color(color_t c);
        longint fx, fy, fz;
        lab_t   res;
        fx = lab_curve(c.x, wp_x);
        fy = lab_curve(c.y, wp_y);
        fz = lab_curve(c.z, wp_z);
        res.l = 16'(clip(to_out_scale(116 * fy - (64'sd16 <<< F_BITS)), 0, L_MAX));
        res.a = 19'(clip(to_out_scale(500 * (fx - fy)), -A_LIM, A_LIM));
        res.b = 17'(clip(to_out_scale(200 * (fy - fz)), -B_LIM, B_LIM));
        return res;
    endfunction

    // Driver: one request per queue entry, with a random gap before each.
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && start && !busy)
            gap_left <= $urandom_range(11);
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy && pending_colors.size() == 0)
            start <= 1'b0;
        else if (start && busy)
            start <= 1'b1;
        else if (pending_colors.size() != 0 && (gap_left == 0 || (start && !busy)))
        begin
            if (!(start && !busy) || gap_left == 0)
            begin
                x_value <= pending_colors[0].x;
                y_value <= pending_colors[0].y;
                z_value <= pending_colors[0].z;
                start   <= 1'b1;
            end
            else
                start <= 1'b0;
        end
        else
        begin
            start <= 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
        end
    end

    // Accepted requests are predicted at the edge that takes them.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            expected_lab.push_back(convert_color(pending_colors.pop_front()));
    end

    // Monitor.
    always @(posedge clk)
    begin
        lab_t want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_lab.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_ERR)
                    $display("unexpected result L=%0d a=%0d b=%0d",
                             lightness, a_axis, b_axis);
            end
            else
            begin
                want = expected_lab.pop_front();
                checked <= checked + 1;
                if (want.l !== lightness || want.a !== a_axis || want.b !== b_axis)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_ERR)
                        $display("mismatch: want L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                                 want.l, want.a, want.b, lightness, a_axis, b_axis);
                end
            end
        end
    end

    task automatic write_white(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        configs++;
        case (idx)
            IDX_WHITE_X: wp_x = val;
            IDX_WHITE_Y: wp_y = val;
            IDX_WHITE_Z: wp_z = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        wait (pending_colors.size() == 0 && !start);
        wait (expected_lab.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_color(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        color_t c;
        c.x = x;
        c.y = y;
        c.z = z;
        pending_colors.push_back(c);
    endtask

    // Ratios near the branch point, around the white point, or fully random.
    function automatic logic [23:0] pick_value(logic [23:0] w);
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = (64'(w) * 216) / 24389 + $urandom_range(4) - 2;
            1: v = $urandom_range(32'(w) * 2);
            2: v = $urandom_range(65535);
            3: v = {$urandom} & 24'hFFFFFF;
            default: v = $urandom_range(32'(w));
        endcase
        return v[23:0];
    endfunction

    task automatic random_batch(int count);
        for (int i = 0; i < count; i++)
            add_color(pick_value(wp_x), pick_value(wp_y), pick_value(wp_z));
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corners: zero, full scale, the white point, the branch boundary.
        add_color(24'd0, 24'd0, 24'd0);
        add_color(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_color(wp_x, wp_y, wp_z);
        add_color(24'hFFFFFF, 24'd0, 24'd0);
        add_color(24'd0, 24'd0, 24'hFFFFFF);
        add_color(24'd0, 24'hFFFFFF, 24'd0);
        add_color(24'd55200, 24'd58044, 24'd63200);
        add_color(24'd55201, 24'd58045, 24'd63201);
        add_color(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        add_color(24'h555555, 24'hAAAAAA, 24'h555555);
        add_color(24'd1, 24'd1, 24'd1);
        wait_idle();

        // Small white points are treated as one; also an unknown index.
        write_white(IDX_WHITE_X, 24'd0);
        write_white(IDX_WHITE_Y, 24'd65535);
        write_white(IDX_WHITE_Z, 24'd65536);
        write_white(2'd3, 24'h123456);
        add_color(24'd0, 24'd0, 24'd0);
        add_color(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_color(24'd579, 24'd580, 24'd581);
        random_batch(200);

        write_white(IDX_WHITE_X, 24'hFFFFFF);
        write_white(IDX_WHITE_Y, 24'hFFFFFF);
        write_white(IDX_WHITE_Z, 24'hFFFFFF);
        add_color(24'hFFFFFF, 24'd0, 24'hFFFFFF);
        random_batch(200);

        write_white(IDX_WHITE_X, 24'd6229125);
        write_white(IDX_WHITE_Y, 24'd6553600);
        write_white(IDX_WHITE_Z, 24'd7135822);
        random_batch(250);

        for (int k = 0; k < 2; k++)
        begin
            write_white(IDX_WHITE_X, 24'($urandom_range(24'hFFFFFF, 65536)));
            write_white(IDX_WHITE_Y, 24'($urandom_range(24'hFFFFFF, 65536)));
            write_white(IDX_WHITE_Z, 24'($urandom_range(24'hFFFFFF, 65536)));
            random_batch(150);
        end

        $display("tb: %0d colors checked over %0d white point writes", checked, configs);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
        begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: done, errors");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("tb: timeout with %0d results outstanding", expected_lab.size());
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/xyzl_pkg.sv
design/xyzl_f.sv
design/xyz_to_cielab.sv
bench/tb.sv
